// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the top level rtl file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CHK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

`else

`define ASSERT_CHK(lbl, clk, rst_n, prop)

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/tdfa_pkg.sv =====
// ----------------------------------------------------------------------------
// tdfa_pkg
// Types and constants of the table driven dfa acceptor
// ----------------------------------------------------------------------------
package tdfa_pkg;

  localparam int TableEntries = 16;
  localparam int StateBits    = 6;
  localparam int SymbolBits   = 8;

  localparam int TabIdxBits = (TableEntries > 1) ? $clog2(TableEntries) : 1;

  localparam int ActionW  = 2;
  localparam int IndexW   = 4;
  localparam int StateW   = 6;
  localparam int SymW     = 8;
  localparam int OutcomeW = 2;
  localparam int MaskW    = 64;
  localparam int CountW   = 5;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 64;

  localparam int QueueDepth = 2;
  localparam int QPtrBits   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  typedef enum logic [ActionW-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SYMBOL = 2'd1,
    ACT_END    = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SYMBOL,
    OP_END
  } op_e;

  typedef enum logic [OutcomeW-1:0] {
    OUT_ACCEPT    = 2'd0,
    OUT_NO_TRANS  = 2'd1,
    OUT_NOT_FINAL = 2'd2
  } outcome_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INITIAL     = 2'd0,
    CFG_FINAL_MASK  = 2'd1,
    CFG_ENTRY_COUNT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    op_e                   op;
    logic [IndexW-1:0]     idx;
    logic [StateBits-1:0]  from_state;
    logic [SymbolBits-1:0] sym;
    logic [StateBits-1:0]  dest;
  } qitem_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [StateW-1:0] initial_state;
    logic [MaskW-1:0]  final_mask;
    logic [CountW-1:0] entry_count;
  } cfg_t;

endpackage

// ===== rtl/tdfa_front.sv =====
// ----------------------------------------------------------------------------
// tdfa_front
// Accepts input requests, decodes the action and pushes work into the queue
// ----------------------------------------------------------------------------
module tdfa_front (
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                action_i,
  input  logic [3:0]                entry_index_i,
  input  logic [5:0]                entry_from_state_i,
  input  logic [7:0]                entry_symbol_type_i,
  input  logic [5:0]                entry_destination_i,
  input  logic [7:0]                symbol_type_i,
  input  tdfa_pkg::q_stat_t         q_stat_i,
  output logic                      push_o,
  output tdfa_pkg::qitem_t          push_item_o
);
  import tdfa_pkg::*;

  logic known;

  assign in_stall_o = q_stat_i.full;

  always_comb begin
    known                  = 1'b1;
    push_item_o.op         = OP_LOAD;
    push_item_o.idx        = entry_index_i;
    push_item_o.from_state = StateBits'(entry_from_state_i);
    push_item_o.sym        = SymbolBits'(entry_symbol_type_i);
    push_item_o.dest       = StateBits'(entry_destination_i);
    case (action_i)
      ACT_LOAD: begin
        push_item_o.op = OP_LOAD;
      end
      ACT_SYMBOL: begin
        push_item_o.op  = OP_SYMBOL;
        push_item_o.sym = SymbolBits'(symbol_type_i);
      end
      ACT_END: begin
        push_item_o.op = OP_END;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // unknown actions are accepted and dropped
  assign push_o = in_valid_i && !q_stat_i.full && known;

endmodule

// ===== rtl/tdfa_queue.sv =====
// ----------------------------------------------------------------------------
// tdfa_queue
// Short fifo of decoded requests between front and back
// ----------------------------------------------------------------------------
module tdfa_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tdfa_pkg::qitem_t  push_item_i,
  input  logic              pop_i,
  output tdfa_pkg::qitem_t  pop_item_o,
  output tdfa_pkg::q_stat_t stat_o
);
  import tdfa_pkg::*;

  localparam int CntBits = $clog2(QueueDepth + 1);

  qitem_t                mem_q [QueueDepth];
  logic [QPtrBits-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrBits-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]    cnt_q, cnt_d;

  function automatic logic [QPtrBits-1:0] ptr_inc(logic [QPtrBits-1:0] p);
    if (p == QPtrBits'(QueueDepth - 1)) begin
      return '0;
    end
    return p + QPtrBits'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntBits'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign pop_item_o   = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CntBits'(QueueDepth));
  assign stat_o.empty = (cnt_q == '0);

endmodule

// ===== rtl/tdfa_back.sv =====
// ----------------------------------------------------------------------------
// tdfa_back
// Transition table, run state and result register
// ----------------------------------------------------------------------------
module tdfa_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tdfa_pkg::cfg_t    cfg_i,
  input  tdfa_pkg::q_stat_t q_stat_i,
  input  tdfa_pkg::qitem_t  item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        outcome_o,
  output logic [5:0]        last_state_o
);
  import tdfa_pkg::*;

  logic [StateBits-1:0]  tab_from_q [TableEntries];
  logic [SymbolBits-1:0] tab_sym_q  [TableEntries];
  logic [StateBits-1:0]  tab_dest_q [TableEntries];

  logic [StateBits-1:0]  state_q, state_d;
  logic                  active_q, active_d;
  logic                  failed_q, failed_d;
  logic                  out_valid_q, out_valid_d;
  outcome_e              outcome_q, outcome_d;
  logic [StateBits-1:0]  last_q, last_d;

  logic [StateBits-1:0]  eff_state;
  logic                  eff_failed;
  logic [TableEntries-1:0] hit;
  logic [StateBits-1:0]  next_state;
  logic                  out_free;
  logic                  is_final;
  logic [TabIdxBits-1:0] wr_idx;
  logic                  wr_en;

  assign eff_state  = active_q ? state_q : StateBits'(cfg_i.initial_state);
  assign eff_failed = active_q && failed_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign pop_o      = !q_stat_i.empty && ((item_i.op != OP_END) || out_free);
  assign is_final   = cfg_i.final_mask[StateW'(eff_state)];

  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      hit[i] = (int'(cfg_i.entry_count) > i) && (tab_from_q[i] == eff_state) &&
               (tab_sym_q[i] == item_i.sym);
    end
  end

  // lowest index wins
  always_comb begin
    next_state = eff_state;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (hit[i]) begin
        next_state = tab_dest_q[i];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    failed_d    = failed_q;
    out_valid_d = out_valid_q && out_stall_i;
    outcome_d   = outcome_q;
    last_d      = last_q;
    if (pop_o) begin
      unique case (item_i.op)
        OP_SYMBOL: begin
          active_d = 1'b1;
          if (eff_failed || (hit == '0)) begin
            state_d  = eff_state;
            failed_d = 1'b1;
          end else begin
            state_d  = next_state;
            failed_d = 1'b0;
          end
        end
        OP_END: begin
          out_valid_d = 1'b1;
          last_d      = eff_state;
          priority if (eff_failed) begin
            outcome_d = OUT_NO_TRANS;
          end else if (is_final) begin
            outcome_d = OUT_ACCEPT;
          end else begin
            outcome_d = OUT_NOT_FINAL;
          end
          active_d = 1'b0;
          failed_d = 1'b0;
          state_d  = StateBits'(cfg_i.initial_state);
        end
        OP_LOAD: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign wr_en  = pop_o && (item_i.op == OP_LOAD) && (int'(item_i.idx) < TableEntries);
  assign wr_idx = TabIdxBits'(item_i.idx);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tab_from_q[wr_idx] <= item_i.from_state;
      tab_sym_q[wr_idx]  <= item_i.sym;
      tab_dest_q[wr_idx] <= item_i.dest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      active_q    <= 1'b0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    outcome_q <= outcome_d;
    last_q    <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign outcome_o    = outcome_q;
  assign last_state_o = StateW'(last_q);

endmodule

// ===== rtl/table_driven_dfa_acceptor_top.sv =====
// ----------------------------------------------------------------------------
// table_driven_dfa_acceptor_top
// Table driven dfa acceptor: decoding front, request queue, table back end
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  in       | in_valid_i / in_stall_o   | action, entry fields, symbol_type
//  out      | out_valid_o / out_stall_i | outcome, last_state
//  cfg      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  one request per cycle unless stalled; all table entries matched in parallel
//  end requests pass the queue, then set the back end result registers
//  the two entry queue absorbs output stalls; in_stall_o rises when it is full
//  reset clears run state, out_valid, cfg; table entries undefined until loaded
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module table_driven_dfa_acceptor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [3:0]  entry_index_i,
  input  logic [5:0]  entry_from_state_i,
  input  logic [7:0]  entry_symbol_type_i,
  input  logic [5:0]  entry_destination_i,
  input  logic [7:0]  symbol_type_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  outcome_o,
  output logic [5:0]  last_state_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import tdfa_pkg::*;

  cfg_t    cfg_q, cfg_d;
  q_stat_t q_stat;
  qitem_t  push_item;
  qitem_t  pop_item;
  logic    push;
  logic    pop;
  logic    end_pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_INITIAL:     cfg_d.initial_state = cfg_data_i[StateW-1:0];
        CFG_FINAL_MASK:  cfg_d.final_mask    = cfg_data_i[MaskW-1:0];
        CFG_ENTRY_COUNT: cfg_d.entry_count   = cfg_data_i[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tdfa_front u_front (
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .action_i            (action_i),
    .entry_index_i       (entry_index_i),
    .entry_from_state_i  (entry_from_state_i),
    .entry_symbol_type_i (entry_symbol_type_i),
    .entry_destination_i (entry_destination_i),
    .symbol_type_i       (symbol_type_i),
    .q_stat_i            (q_stat),
    .push_o              (push),
    .push_item_o         (push_item)
  );

  tdfa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .stat_o      (q_stat)
  );

  tdfa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_stat_i     (q_stat),
    .item_i       (pop_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .outcome_o    (outcome_o),
    .last_state_o (last_state_o)
  );

  assign end_pop = pop && (pop_item.op == OP_END);

  `ASSERT_CHK(a_queue_status, clk_i, rst_ni, !(q_stat.full && q_stat.empty))
  `ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, push, !q_stat.full)
  `ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, pop, !q_stat.empty)
  `ASSERT_IMPL(a_result_source, clk_i, rst_ni, $rose(out_valid_o), $past(end_pop))

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the table driven dfa acceptor. Requests are queued
// by a stimulus process, sent by a clocked driver with random gaps and checked
// against an in-bench automaton model as the receiver stalls at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import tdfa_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES   = 10;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_REQUESTS = 55;

  typedef struct packed {
    logic [1:0] act;
    logic [3:0] slot;
    logic [5:0] from_st;
    logic [7:0] ent_sym;
    logic [5:0] dest_st;
    logic [7:0] sym;
  } request_t;

  typedef struct packed {
    outcome_e   outcome;
    logic [5:0] last_state;
  } verdict_t;

  logic        clk_i               = 1'b0;
  logic        rst_ni              = 1'b0;
  logic        in_valid_i          = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i            = '0;
  logic [3:0]  entry_index_i       = '0;
  logic [5:0]  entry_from_state_i  = '0;
  logic [7:0]  entry_symbol_type_i = '0;
  logic [5:0]  entry_destination_i = '0;
  logic [7:0]  symbol_type_i       = '0;
  logic        out_valid_o;
  logic        out_stall_i         = 1'b0;
  logic [1:0]  outcome_o;
  logic [5:0]  last_state_o;
  logic        cfg_valid_i         = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i         = '0;
  logic [63:0] cfg_data_i          = '0;

  request_t pending_q[$];
  verdict_t verdicts_q[$];

  // automaton model state
  logic [5:0]  init_st   = '0;
  logic [63:0] fin_mask  = '0;
  logic [4:0]  n_entries = '0;
  logic [5:0]  cur_st    = '0;
  bit          run_on    = 1'b0;
  bit          run_bad   = 1'b0;
  logic [5:0]  tab_from [TableEntries];
  logic [7:0]  tab_sym  [TableEntries];
  logic [5:0]  tab_dest [TableEntries];

  bit calm      = 1'b0;
  bit hold_arm  = 1'b0;
  bit hold_used = 1'b0;
  int gap_left, stall_left, hold_left, idle_cycles;
  int errors, n_loads, n_syms, n_ends, n_phases;
  int n_accept, n_no_trans, n_not_final;

  table_driven_dfa_acceptor_top dut (.*);

  always #4 clk_i = ~clk_i;

  function automatic request_t mk(input logic [1:0] a, input logic [3:0] s,
                                  input logic [5:0] f, input logic [7:0] e,
                                  input logic [5:0] d, input logic [7:0] y);
    request_t r;
    r.act = a; r.slot = s; r.from_st = f; r.ent_sym = e; r.dest_st = d; r.sym = y;
    return r;
  endfunction

  function automatic void add_request(input request_t r);
    pending_q = {pending_q, r};
  endfunction

  task automatic apply_request();
    int lim;
    bit hit;
    verdict_t v;
    case (action_i)
      ACT_LOAD: begin
        tab_from[entry_index_i] = entry_from_state_i;
        tab_sym[entry_index_i]  = entry_symbol_type_i;
        tab_dest[entry_index_i] = entry_destination_i;
        n_loads++;
      end
      ACT_SYMBOL: begin
        n_syms++;
        if (!run_on) begin
          cur_st  = init_st;
          run_on  = 1'b1;
          run_bad = 1'b0;
        end
        if (!run_bad) begin
          lim = (n_entries > TableEntries) ? TableEntries : n_entries;
          hit = 1'b0;
          for (int i = 0; i < lim && !hit; i++) begin
            if (tab_from[i] == cur_st && tab_sym[i] == symbol_type_i) begin
              cur_st = tab_dest[i];
              hit    = 1'b1;
            end
          end
          if (!hit) run_bad = 1'b1;
        end
      end
      ACT_END: begin
        n_ends++;
        if (!run_on) cur_st = init_st;
        if (run_bad) v.outcome = OUT_NO_TRANS;
        else if (fin_mask[cur_st]) v.outcome = OUT_ACCEPT;
        else v.outcome = OUT_NOT_FINAL;
        v.last_state = cur_st;
        verdicts_q = {verdicts_q, v};
        run_on  = 1'b0;
        run_bad = 1'b0;
        cur_st  = init_st;
      end
      default: ;
    endcase
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : driver
    request_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) apply_request();
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() != 0) begin
          nxt = pending_q.pop_front();
          in_valid_i          <= 1'b1;
          action_i            <= nxt.act;
          entry_index_i       <= nxt.slot;
          entry_from_state_i  <= nxt.from_st;
          entry_symbol_type_i <= nxt.ent_sym;
          entry_destination_i <= nxt.dest_st;
          symbol_type_i       <= nxt.sym;
          if (!calm && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 17);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result stall generator
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (hold_arm && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 16);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin : monitor
    verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdicts_q.size() == 0) begin
        $display("%0t: result with none expected, outcome %0d last_state %0d",
                 $time, outcome_o, last_state_o);
        errors++;
      end else begin
        want = verdicts_q.pop_front();
        case (want.outcome)
          OUT_ACCEPT:   n_accept++;
          OUT_NO_TRANS: n_no_trans++;
          default:      n_not_final++;
        endcase
        if (outcome_o !== want.outcome) begin
          $display("%0t: outcome mismatch, expected %0d actual %0d",
                   $time, want.outcome, outcome_o);
          errors++;
        end
        if (last_state_o !== want.last_state) begin
          $display("%0t: last_state mismatch, expected %0d actual %0d",
                   $time, want.last_state, last_state_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_INITIAL:    init_st   = val[5:0];
      CFG_FINAL_MASK: fin_mask  = val;
      default:        n_entries = val[4:0];
    endcase
  endtask

  task automatic set_regs(input logic [5:0] st, input logic [63:0] mask,
                          input logic [4:0] cnt);
    write_reg(CFG_INITIAL, 64'(st));
    write_reg(CFG_FINAL_MASK, mask);
    write_reg(CFG_ENTRY_COUNT, 64'(cnt));
    n_phases++;
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || verdicts_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_random(input int ph, input logic [4:0] cnt);
    logic [5:0]  st [4];
    logic [7:0]  sy [4];
    logic [63:0] mask;
    request_t    q;
    int          r;
    settle();
    foreach (st[k]) begin
      st[k] = $urandom_range(0, 63);
      sy[k] = $urandom_range(0, 255);
    end
    if (ph == 0) mask = '0;
    else if (ph == 1) mask = '1;
    else if ($urandom_range(0, 3) == 0) mask = {$urandom, $urandom};
    else begin
      mask = '0;
      foreach (st[k]) if ($urandom_range(0, 1)) mask[st[k]] = 1'b1;
    end
    set_regs(st[$urandom_range(0, 3)], mask, cnt);
    @(negedge clk_i);
    for (int i = 0; i < TableEntries; i++) begin
      add_request(mk(ACT_LOAD, 4'(i), st[$urandom_range(0, 3)], sy[$urandom_range(0, 3)],
                     st[$urandom_range(0, 3)], $urandom));
    end
    for (int n = 0; n < PHASE_REQUESTS; n++) begin
      r = $urandom_range(0, 99);
      q = mk(ACT_SYMBOL, $urandom, $urandom, $urandom, $urandom, sy[$urandom_range(0, 3)]);
      if (r < 62) ;
      else if (r < 80) q.act = ACT_END;
      else if (r < 88) begin
        q.act     = ACT_LOAD;
        q.from_st = st[$urandom_range(0, 3)];
        q.ent_sym = sy[$urandom_range(0, 3)];
        q.dest_st = st[$urandom_range(0, 3)];
      end else if (r < 94) q.sym = $urandom;
      else if (r < 97) q.act = ACT_LOAD;
      else q.act = ACT_UNUSED;
      add_request(q);
    end
    hold_arm = (ph == 3);
    calm     = (ph >= RANDOM_PHASES - 2);
  endtask

  initial begin : stimulus
    logic [4:0] counts [RANDOM_PHASES] = '{16, 31, 1, 16, 0, 16, 9, 16, 17, 16};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty runs, no entries in use, unknown action, extreme entries
    set_regs(6'd63, 64'h8000_0000_0000_0000, 5'd0);
    @(negedge clk_i);
    add_request(mk(ACT_END, 0, 0, 0, 0, 0));
    add_request(mk(ACT_SYMBOL, 0, 0, 0, 0, 8'hff));
    add_request(mk(ACT_END, 0, 0, 0, 0, 0));
    add_request(mk(ACT_UNUSED, 4'hf, 6'h3f, 8'hff, 6'h3f, 8'hff));
    add_request(mk(ACT_LOAD, 0, 6'd63, 8'd255, 6'd0, 0));
    add_request(mk(ACT_LOAD, 1, 6'd0, 8'd0, 6'd63, 8'hff));
    add_request(mk(ACT_LOAD, 2, 6'd63, 8'd255, 6'd5, 0));
    add_request(mk(ACT_LOAD, 3, 6'd0, 8'd1, 6'd62, 0));
    add_request(mk(ACT_LOAD, 15, $urandom, $urandom, $urandom, 0));
    settle();

    // priority among matching entries, failed runs, non-final stop
    set_regs(6'd0, 64'h8000_0000_0000_0001, 5'd4);
    @(negedge clk_i);
    add_request(mk(ACT_END, 0, 0, 0, 0, 0));
    add_request(mk(ACT_SYMBOL, 0, 0, 0, 0, 8'd0));
    add_request(mk(ACT_SYMBOL, 0, 0, 0, 0, 8'd255));
    add_request(mk(ACT_END, 0, 0, 0, 0, 0));
    add_request(mk(ACT_SYMBOL, 0, 0, 0, 0, 8'd1));
    add_request(mk(ACT_END, 0, 0, 0, 0, 0));
    add_request(mk(ACT_SYMBOL, 0, 0, 0, 0, 8'd0));
    add_request(mk(ACT_SYMBOL, 0, 0, 0, 0, 8'd0));
    add_request(mk(ACT_SYMBOL, 0, 0, 0, 0, 8'd255));
    add_request(mk(ACT_UNUSED, 0, 0, 0, 0, 0));
    add_request(mk(ACT_END, 0, 0, 0, 0, 0));

    for (int ph = 0; ph < RANDOM_PHASES; ph++) run_random(ph, counts[ph]);
    settle();

    $display("covered %0d loads, %0d symbols and %0d ends under %0d register settings",
             n_loads, n_syms, n_ends, n_phases);
    $display("results: %0d accepted, %0d no transition, %0d not final, %0d errors",
             n_accept, n_no_trans, n_not_final, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
